// ===== src/csmf_pkg.sv =====
// shared constants, types and codes of the cross stencil mean filter
package csmf_pkg;

  localparam int MAX_WIDTH  = 2048;
  localparam int MAX_HEIGHT = 2048;

  localparam int CFG_W   = 12;
  localparam int COL_W   = $clog2(MAX_WIDTH);
  localparam int ROW_W   = $clog2(MAX_HEIGHT);
  localparam int WSIZE_W = COL_W + 1;
  localparam int HSIZE_W = ROW_W + 1;

  localparam logic [CFG_W-1:0] FRAME_WIDTH_RST  = CFG_W'(640);
  localparam logic [CFG_W-1:0] FRAME_HEIGHT_RST = CFG_W'(480);

  localparam int CH_W  = 8;
  localparam int SUM_W = CH_W + 3;

  // truncating divide by five as multiply by reciprocal, exact for sums up to 5 * 255
  localparam int DIV5_MUL_W = 16;
  localparam int DIV5_MUL   = 52429;
  localparam int DIV5_SHIFT = 18;
  localparam int PROD_W     = SUM_W + DIV5_MUL_W;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int CNT_W      = FIFO_AW + 1;

  typedef enum logic [0:0] {
    REQ_PIXEL = 1'b0,
    REQ_DRAIN = 1'b1
  } req_type_e;

  typedef enum logic [0:0] {
    CFG_FRAME_WIDTH  = 1'b0,
    CFG_FRAME_HEIGHT = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
  } pixel_t;

  typedef struct packed {
    logic up;
    logic down;
    logic left;
    logic right;
  } nbr_mask_t;

  typedef struct packed {
    logic row_end;
    logic frame_end;
  } res_tag_t;

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
    res_tag_t        tag;
  } result_t;

  typedef struct packed {
    logic             has_res;
    logic             pixel;
    logic [COL_W-1:0] addr;
    pixel_t           px;
    nbr_mask_t        mask;
    res_tag_t         tag;
  } stage_op_t;

endpackage

// ===== src/csmf_req_if.sv =====
// request channel carrying raster pixels and drain requests
interface csmf_req_if;
  logic                       valid;
  logic                       ready;
  logic                       req_type;
  logic [csmf_pkg::CH_W-1:0]  in_red;
  logic [csmf_pkg::CH_W-1:0]  in_green;
  logic [csmf_pkg::CH_W-1:0]  in_blue;

  modport source (output valid, req_type, in_red, in_green, in_blue, input ready);
  modport sink   (input valid, req_type, in_red, in_green, in_blue, output ready);
endinterface

// ===== src/csmf_res_if.sv =====
// result channel carrying smoothed pixels and row and frame marks
interface csmf_res_if;
  logic                       valid;
  logic                       ready;
  logic [csmf_pkg::CH_W-1:0]  out_red;
  logic [csmf_pkg::CH_W-1:0]  out_green;
  logic [csmf_pkg::CH_W-1:0]  out_blue;
  logic                       row_end;
  logic                       frame_end;

  modport source (output valid, out_red, out_green, out_blue, row_end, frame_end,
                  input ready);
  modport sink   (input valid, out_red, out_green, out_blue, row_end, frame_end,
                  output ready);
endinterface

// ===== src/cross_stencil_mean_filter.sv =====
// top level of the five point cross mean filter with two row stores
// path: a request passes the stage one register, the lane sum register and the output queue
// throughput: one request per cycle while ready is high, set by the single write port of each row store
// ready drops only while the 4 entry output queue and the pipeline hold 4 results
// reset: counters, pending drain and pipeline cleared, frame size back to 640 x 480
// reset: row stores are not cleared and hold old contents until written
module cross_stencil_mean_filter (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  csmf_pkg::cfg_reg_e         cfg_index,
  input  logic [csmf_pkg::CFG_W-1:0] cfg_data,
  csmf_req_if.sink                   req,
  csmf_res_if.source                 res
);
  import csmf_pkg::*;

  logic [CFG_W-1:0]   frame_width;
  logic [CFG_W-1:0]   frame_height;
  logic [COL_W-1:0]   input_column;
  logic [ROW_W-1:0]   input_row;
  logic [COL_W-1:0]   output_column;
  logic               pending;

  logic [WSIZE_W-1:0] w_eff;
  logic [HSIZE_W-1:0] h_eff;
  logic [COL_W-1:0]   ic;
  logic [ROW_W-1:0]   ir;
  logic [COL_W-1:0]   oc;
  logic               accept;
  logic               is_pixel;
  logic               last_col;
  logic               last_row;
  stage_op_t          op_next;

  logic               s1_valid;
  stage_op_t          s1;
  logic               s2_res;
  res_tag_t           s2_tag;

  logic               fwd_valid;
  logic               fwd_cwe;
  logic [COL_W-1:0]   fwd_addr;
  pixel_t             fwd_udata;
  pixel_t             fwd_cdata;

  pixel_t             up_rd_a;
  pixel_t             up_rd_b;
  pixel_t             ctr_rd_a;
  pixel_t             ctr_rd_b;
  pixel_t             centre_v;
  pixel_t             up_v;
  pixel_t             left_v;
  pixel_t             right_v;

  logic [CH_W-1:0]    mean_red;
  logic [CH_W-1:0]    mean_green;
  logic [CH_W-1:0]    mean_blue;
  logic [CNT_W-1:0]   fifo_count;
  logic [CNT_W:0]     occupancy;
  logic               s1_res;

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= FRAME_WIDTH_RST;
      frame_height <= FRAME_HEIGHT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_FRAME_WIDTH:  frame_width  <= cfg_data;
        CFG_FRAME_HEIGHT: frame_height <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (frame_width == '0)              w_eff = WSIZE_W'(1);
    else if (32'(frame_width) > MAX_WIDTH) w_eff = WSIZE_W'(MAX_WIDTH);
    else                                w_eff = WSIZE_W'(frame_width);
    if (frame_height == '0)               h_eff = HSIZE_W'(1);
    else if (32'(frame_height) > MAX_HEIGHT) h_eff = HSIZE_W'(MAX_HEIGHT);
    else                                  h_eff = HSIZE_W'(frame_height);
  end

  // request decode and position tracking
  assign s1_res    = s1_valid && s1.has_res;
  assign occupancy = {1'b0, fifo_count} + (CNT_W+1)'(s1_res) + (CNT_W+1)'(s2_res);
  assign req.ready = (occupancy < (CNT_W+1)'(FIFO_DEPTH));
  assign accept    = req.valid && req.ready;
  assign is_pixel  = (req.req_type == REQ_PIXEL);

  assign ic = ({1'b0, input_column} < w_eff) ? input_column : '0;
  assign ir = ({1'b0, input_row} < h_eff) ? input_row : '0;
  assign oc = ({1'b0, output_column} < w_eff) ? output_column : '0;

  always_comb begin
    op_next.pixel = is_pixel;
    op_next.addr  = is_pixel ? ic : oc;
    op_next.px    = '{red: req.in_red, green: req.in_green, blue: req.in_blue};
    last_col      = ((WSIZE_W'(op_next.addr) + WSIZE_W'(1)) == w_eff);
    last_row      = ((HSIZE_W'(ir) + HSIZE_W'(1)) == h_eff);
    if (is_pixel) begin
      op_next.has_res       = (ir != '0);
      op_next.mask.up       = (ir > ROW_W'(1));
      op_next.mask.down     = 1'b1;
      op_next.tag.frame_end = 1'b0;
    end else begin
      op_next.has_res       = 1'b1;
      op_next.mask.up       = (h_eff > HSIZE_W'(1));
      op_next.mask.down     = 1'b0;
      op_next.tag.frame_end = last_col;
    end
    op_next.mask.left   = (op_next.addr != '0);
    op_next.mask.right  = !last_col;
    op_next.tag.row_end = last_col;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      input_column  <= '0;
      input_row     <= '0;
      output_column <= '0;
      pending       <= 1'b0;
    end else if (accept) begin
      if (is_pixel) begin
        pending <= 1'b0;
        if (!last_col) begin
          input_column <= ic + COL_W'(1);
          input_row    <= ir;
        end else if (!last_row) begin
          input_column <= '0;
          input_row    <= ir + ROW_W'(1);
        end else begin
          input_column  <= '0;
          input_row     <= '0;
          output_column <= '0;
          pending       <= 1'b1;
        end
      end else if (pending) begin
        if (!last_col) begin
          output_column <= oc + COL_W'(1);
        end else begin
          output_column <= '0;
          pending       <= 1'b0;
        end
      end
    end
  end

  // stage one: row store reads come back, write back with forwarding
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_res    <= 1'b0;
      fwd_valid <= 1'b0;
      fwd_cwe   <= 1'b0;
    end else begin
      s1_valid  <= accept && (is_pixel || pending);
      s2_res    <= s1_res;
      fwd_valid <= s1_valid;
      fwd_cwe   <= s1_valid && s1.pixel;
    end
  end

  always_ff @(posedge clk) begin
    s1        <= op_next;
    s2_tag    <= s1.tag;
    fwd_addr  <= s1.addr;
    fwd_udata <= centre_v;
    fwd_cdata <= s1.px;
  end

  csmf_line_store u_upper_store (
    .clk     (clk),
    .we      (s1_valid),
    .waddr   (s1.addr),
    .wdata   (centre_v),
    .raddr_a (op_next.addr),
    .raddr_b (op_next.addr - COL_W'(1)),
    .rdata_a (up_rd_a),
    .rdata_b (up_rd_b)
  );

  csmf_line_store u_centre_store (
    .clk     (clk),
    .we      (s1_valid && s1.pixel),
    .waddr   (s1.addr),
    .wdata   (s1.px),
    .raddr_a (op_next.addr),
    .raddr_b (op_next.addr + COL_W'(1)),
    .rdata_a (ctr_rd_a),
    .rdata_b (ctr_rd_b)
  );

  assign centre_v = (fwd_cwe && fwd_addr == s1.addr) ? fwd_cdata : ctr_rd_a;
  assign right_v  = (fwd_cwe && fwd_addr == s1.addr + COL_W'(1)) ? fwd_cdata : ctr_rd_b;
  assign up_v     = (fwd_valid && fwd_addr == s1.addr) ? fwd_udata : up_rd_a;
  assign left_v   = (fwd_valid && fwd_addr == s1.addr - COL_W'(1)) ? fwd_udata : up_rd_b;

  // color lanes
  csmf_lane u_lane_red (
    .clk    (clk),
    .mask   (s1.mask),
    .centre (centre_v.red),
    .up     (up_v.red),
    .down   (s1.px.red),
    .left   (left_v.red),
    .right  (right_v.red),
    .mean   (mean_red)
  );

  csmf_lane u_lane_green (
    .clk    (clk),
    .mask   (s1.mask),
    .centre (centre_v.green),
    .up     (up_v.green),
    .down   (s1.px.green),
    .left   (left_v.green),
    .right  (right_v.green),
    .mean   (mean_green)
  );

  csmf_lane u_lane_blue (
    .clk    (clk),
    .mask   (s1.mask),
    .centre (centre_v.blue),
    .up     (up_v.blue),
    .down   (s1.px.blue),
    .left   (left_v.blue),
    .right  (right_v.blue),
    .mean   (mean_blue)
  );

  csmf_merge u_merge (
    .clk        (clk),
    .rst        (rst),
    .push       (s2_res),
    .mean_red   (mean_red),
    .mean_green (mean_green),
    .mean_blue  (mean_blue),
    .tag        (s2_tag),
    .count      (fifo_count),
    .res        (res)
  );

  // checks
  assert property (@(posedge clk) disable iff (rst)
    occupancy <= (CNT_W+1)'(FIFO_DEPTH))
    else $error("results in flight exceed output queue space");

  assert property (@(posedge clk) disable iff (rst)
    pending |-> (input_column == '0 && input_row == '0))
    else $error("drain pending while input position is inside a frame");

  assert property (@(posedge clk) disable iff (rst)
    s2_res |-> $past(s1_valid && s1.has_res))
    else $error("lane result without a request one cycle before");

  assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !s1.pixel) |-> $past(pending))
    else $error("drain reached the row stores with nothing pending");

endmodule

// ===== src/csmf_line_store.sv =====
// row store: one write port and two registered read ports
module csmf_line_store (
  input  logic                       clk,
  input  logic                       we,
  input  logic [csmf_pkg::COL_W-1:0] waddr,
  input  csmf_pkg::pixel_t           wdata,
  input  logic [csmf_pkg::COL_W-1:0] raddr_a,
  input  logic [csmf_pkg::COL_W-1:0] raddr_b,
  output csmf_pkg::pixel_t           rdata_a,
  output csmf_pkg::pixel_t           rdata_b
);
  import csmf_pkg::*;

  pixel_t mem [MAX_WIDTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

// ===== src/csmf_lane.sv =====
// one color lane: masked five point sum, registered, then divide by five
module csmf_lane (
  input  logic                      clk,
  input  csmf_pkg::nbr_mask_t       mask,
  input  logic [csmf_pkg::CH_W-1:0] centre,
  input  logic [csmf_pkg::CH_W-1:0] up,
  input  logic [csmf_pkg::CH_W-1:0] down,
  input  logic [csmf_pkg::CH_W-1:0] left,
  input  logic [csmf_pkg::CH_W-1:0] right,
  output logic [csmf_pkg::CH_W-1:0] mean
);
  import csmf_pkg::*;

  logic [SUM_W-1:0]  sum;
  logic [SUM_W-1:0]  sum_next;
  logic [PROD_W-1:0] prod;

  always_comb begin
    sum_next = SUM_W'(centre);
    if (mask.up)    sum_next = sum_next + SUM_W'(up);
    if (mask.down)  sum_next = sum_next + SUM_W'(down);
    if (mask.left)  sum_next = sum_next + SUM_W'(left);
    if (mask.right) sum_next = sum_next + SUM_W'(right);
  end

  always_ff @(posedge clk) begin
    sum <= sum_next;
  end

  assign prod = PROD_W'(sum) * PROD_W'(DIV5_MUL);
  assign mean = CH_W'(prod >> DIV5_SHIFT);

endmodule

// ===== src/csmf_merge.sv =====
// merges lane results with row and frame marks into the output queue
module csmf_merge (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push,
  input  logic [csmf_pkg::CH_W-1:0]  mean_red,
  input  logic [csmf_pkg::CH_W-1:0]  mean_green,
  input  logic [csmf_pkg::CH_W-1:0]  mean_blue,
  input  csmf_pkg::res_tag_t         tag,
  output logic [csmf_pkg::CNT_W-1:0] count,
  csmf_res_if.source                 res
);
  import csmf_pkg::*;

  result_t            queue [FIFO_DEPTH];
  logic [FIFO_AW-1:0] head;
  logic [FIFO_AW-1:0] tail;
  logic               pop;
  result_t            head_item;

  assign pop       = res.valid && res.ready;
  assign head_item = queue[head];

  always_ff @(posedge clk) begin
    if (push) begin
      queue[tail] <= '{red: mean_red, green: mean_green, blue: mean_blue, tag: tag};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      if (push) tail <= tail + FIFO_AW'(1);
      if (pop)  head <= head + FIFO_AW'(1);
      count <= count + CNT_W'(push) - CNT_W'(pop);
    end
  end

  assign res.valid     = (count != '0);
  assign res.out_red   = head_item.red;
  assign res.out_green = head_item.green;
  assign res.out_blue  = head_item.blue;
  assign res.row_end   = head_item.tag.row_end;
  assign res.frame_end = head_item.tag.frame_end;

endmodule

// ===== sim/tb_cross_stencil_mean_filter.sv =====
// testbench of the cross stencil mean filter: line store predictor, request driver, result checks
module tb_cross_stencil_mean_filter;
  import csmf_pkg::*;

  localparam int unsigned CYCLE_LIMIT     = 800000;
  localparam int unsigned SETTLE_CYCLES   = 8;
  localparam int unsigned RANDOM_ITEMS    = 1500;
  localparam int unsigned BOUNDARY_PIXELS = 40;

  class smoothing_scoreboard;
    pixel_t           upper_line  [MAX_WIDTH];
    pixel_t           centre_line [MAX_WIDTH];
    int unsigned      in_col, in_row, out_col;
    bit               drain_due;
    logic [CFG_W-1:0] width_reg, height_reg;
    int unsigned      acc_red, acc_green, acc_blue;
    result_t          pending_results [$];
    int unsigned      errors, results_checked, pixels_seen, drains_seen, size_writes;

    function new();
      width_reg  = FRAME_WIDTH_RST;
      height_reg = FRAME_HEIGHT_RST;
      in_col = 0;
      in_row = 0;
      out_col = 0;
      drain_due = 1'b0;
      errors = 0;
      results_checked = 0;
      pixels_seen = 0;
      drains_seen = 0;
      size_writes = 0;
    endfunction

    function int unsigned clamp_size(logic [CFG_W-1:0] v, int unsigned most);
      if (v == 0) return 1;
      return (v > most) ? most : v;
    endfunction

    function void note_size_write(cfg_reg_e idx, logic [CFG_W-1:0] v);
      case (idx)
        CFG_FRAME_WIDTH:  width_reg = v;
        CFG_FRAME_HEIGHT: height_reg = v;
        default: ;
      endcase
      size_writes++;
    endfunction

    function void accumulate(pixel_t p);
      acc_red   += p.red;
      acc_green += p.green;
      acc_blue  += p.blue;
    endfunction

    function result_t cross_mean(int unsigned row, int unsigned col, int unsigned w,
                                 int unsigned h, bit has_below, pixel_t below);
      result_t r;
      acc_red = 0;
      acc_green = 0;
      acc_blue = 0;
      accumulate(centre_line[col]);
      if (row > 0) accumulate(upper_line[col]);
      if (has_below) accumulate(below);
      if (col > 0) accumulate(upper_line[col - 1]);
      if (col + 1 < w) accumulate(centre_line[col + 1]);
      r.red   = 8'(acc_red / 5);
      r.green = 8'(acc_green / 5);
      r.blue  = 8'(acc_blue / 5);
      r.tag.row_end   = (col + 1 == w);
      r.tag.frame_end = (col + 1 == w) && (row + 1 == h);
      return r;
    endfunction

    function void note_request(req_type_e kind, pixel_t px);
      int unsigned w, h, ic, ir, oc;
      bit made;
      w = clamp_size(width_reg, MAX_WIDTH);
      h = clamp_size(height_reg, MAX_HEIGHT);
      if (kind == REQ_PIXEL) begin
        pixels_seen++;
        ic = (in_col < w) ? in_col : 0;
        ir = (in_row < h) ? in_row : 0;
        made = 1'b0;
        if (ir > 0) begin
          pending_results.push_back(cross_mean(ir - 1, ic, w, h, 1'b1, px));
          made = 1'b1;
        end
        upper_line[ic]  = centre_line[ic];
        centre_line[ic] = px;
        drain_due = 1'b0;
        if (ic + 1 < w) begin
          in_col = ic + 1;
          in_row = ir;
          if (made) out_col = ic + 1;
        end else if (ir + 1 < h) begin
          in_col = 0;
          in_row = ir + 1;
          if (made) out_col = 0;
        end else begin
          in_col = 0;
          in_row = 0;
          out_col = 0;
          drain_due = 1'b1;
        end
      end else begin
        drains_seen++;
        if (drain_due) begin
          oc = (out_col < w) ? out_col : 0;
          pending_results.push_back(cross_mean(h - 1, oc, w, h, 1'b0, '0));
          upper_line[oc] = centre_line[oc];
          if (oc + 1 < w) begin
            out_col = oc + 1;
          end else begin
            out_col = 0;
            drain_due = 1'b0;
          end
        end
      end
    endfunction

    function void compare_field(string field, logic [7:0] want, logic [7:0] seen);
      if (seen !== want) begin
        $error("%s expected %0d got %0d", field, want, seen);
        errors++;
      end
    endfunction

    function void check_result(result_t seen);
      result_t want;
      if (pending_results.size() == 0) begin
        $error("smoothed pixel arrived with none expected");
        errors++;
        return;
      end
      want = pending_results.pop_front();
      results_checked++;
      compare_field("out_red", want.red, seen.red);
      compare_field("out_green", want.green, seen.green);
      compare_field("out_blue", want.blue, seen.blue);
      compare_field("row_end", 8'(want.tag.row_end), 8'(seen.tag.row_end));
      compare_field("frame_end", 8'(want.tag.frame_end), 8'(seen.tag.frame_end));
    endfunction
  endclass

  logic             clk;
  logic             rst;
  logic             cfg_we;
  cfg_reg_e         cfg_index;
  logic [CFG_W-1:0] cfg_data;

  csmf_req_if pixel_in ();
  csmf_res_if pixel_out ();

  cross_stencil_mean_filter dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req       (pixel_in),
    .res       (pixel_out)
  );

  smoothing_scoreboard sb = new();

  int unsigned send_gap_pct   = 10;
  int unsigned sink_stall_pct = 58;
  int unsigned frame_w        = 640;
  int unsigned frame_h        = 480;
  int unsigned drains_left    = 0;
  int unsigned useful_requests = 0;
  int unsigned cycle_count    = 0;

  initial begin
    clk = 1'b0;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = CFG_FRAME_WIDTH;
    cfg_data = '0;
    pixel_in.valid = 1'b0;
    pixel_in.req_type = REQ_PIXEL;
    pixel_in.in_red = '0;
    pixel_in.in_green = '0;
    pixel_in.in_blue = '0;
    pixel_out.ready = 1'b0;
  end

  always #6 clk = ~clk;

  always @(posedge clk) begin
    pixel_out.ready <= ($urandom_range(99) >= sink_stall_pct);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // results first, so an unexpected one never pairs with a request of the same edge
  always @(posedge clk) begin
    if (!rst) begin
      if (pixel_out.valid && pixel_out.ready) begin
        sb.check_result({pixel_out.out_red, pixel_out.out_green, pixel_out.out_blue,
                         pixel_out.row_end, pixel_out.frame_end});
      end
      if (pixel_in.valid && pixel_in.ready) begin
        sb.note_request(req_type_e'(pixel_in.req_type),
                        {pixel_in.in_red, pixel_in.in_green, pixel_in.in_blue});
      end
      if (cfg_we) sb.note_size_write(cfg_index, cfg_data);
    end
  end

  function automatic pixel_t random_pixel();
    case ($urandom_range(7))
      0: return '0;
      1: return '1;
      default: return pixel_t'($urandom);
    endcase
  endfunction

  task automatic push_request(input req_type_e kind, input pixel_t px);
    if ($urandom_range(99) < send_gap_pct) begin
      pixel_in.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_gap_pct);
    end
    pixel_in.valid <= 1'b1;
    pixel_in.req_type <= kind;
    {pixel_in.in_red, pixel_in.in_green, pixel_in.in_blue} <= px;
    do @(posedge clk); while (!pixel_in.ready);
  endtask

  task automatic send_pixels(input int unsigned count);
    repeat (count) push_request(REQ_PIXEL, random_pixel());
    useful_requests += count;
    drains_left = 0;
  endtask

  task automatic send_drains(input int unsigned count);
    repeat (count) begin
      push_request(REQ_DRAIN, random_pixel());
      if (drains_left > 0) begin
        drains_left--;
        useful_requests++;
      end
    end
  endtask

  task automatic send_frame();
    send_pixels(frame_w * frame_h);
    drains_left = frame_w;
  endtask

  task automatic settle();
    pixel_in.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_frame_size(input int unsigned width, input int unsigned height);
    cfg_we <= 1'b1;
    cfg_index <= CFG_FRAME_WIDTH;
    cfg_data <= CFG_W'(width);
    @(posedge clk);
    cfg_index <= CFG_FRAME_HEIGHT;
    cfg_data <= CFG_W'(height);
    @(posedge clk);
    cfg_we <= 1'b0;
    frame_w = sb.clamp_size(CFG_W'(width), MAX_WIDTH);
    frame_h = sb.clamp_size(CFG_W'(height), MAX_HEIGHT);
  endtask

  task automatic resize(input int unsigned width, input int unsigned height);
    send_drains(drains_left);
    settle();
    set_frame_size(width, height);
  endtask

  // partial frame at an extreme size, then a 1 x 1 size puts the input back at the frame start
  task automatic touch_size_limits(input int unsigned width, input int unsigned height);
    resize(width, height);
    send_pixels(BOUNDARY_PIXELS);
    settle();
    set_frame_size(1, 1);
  endtask

  // primed frame, then a request stream cut mid-frame and resized to a random size no wider
  task automatic cut_frame_short();
    int unsigned wide, tall, sent, col, row;
    wide = $urandom_range(4, 12);
    tall = $urandom_range(2, 6);
    resize(wide, tall);
    send_frame();
    send_drains(wide);
    sent = $urandom_range(1, wide * tall - 1);
    send_pixels(sent);
    settle();
    set_frame_size($urandom_range(1, wide), $urandom_range(1, 6));
    col = sent % wide;
    row = sent / wide;
    if (col >= frame_w) col = 0;
    if (row >= frame_h) row = 0;
    send_pixels(frame_w * frame_h - (row * frame_w + col));
    drains_left = frame_w;
    send_drains(frame_w);
  endtask

  // last row partly drained, then the width is set anew, possibly below the drain position
  task automatic resize_while_draining();
    int unsigned wide, taken, rest;
    wide = $urandom_range(2, 12);
    resize(wide, $urandom_range(2, 5));
    send_frame();
    taken = $urandom_range(1, wide - 1);
    send_drains(taken);
    settle();
    set_frame_size($urandom_range(1, wide), $urandom_range(1, 6));
    rest = (taken < frame_w) ? frame_w - taken : frame_w;
    drains_left = rest;
    send_drains(rest);
  endtask

  task automatic random_flow(input int unsigned quota);
    int unsigned goal, pick;
    goal = useful_requests + quota;
    while (useful_requests < goal) begin
      case ($urandom_range(9))
        0: cut_frame_short();
        1: resize_while_draining();
        2: send_drains($urandom_range(1, 3));
        default: begin
          if ($urandom_range(2) == 0) begin
            pick = $urandom_range(99);
            resize(pick < 2 ? 0 : (pick < 17 ? $urandom_range(13, 48) : $urandom_range(1, 12)),
                   pick > 96 ? 0 : $urandom_range(1, 8));
          end
          send_frame();
          if ($urandom_range(4) == 0) send_drains($urandom_range(frame_w - 1));
          else send_drains(frame_w + $urandom_range(1));
        end
      endcase
    end
  endtask

  task automatic directed_requests();
    // drain request with nothing pending
    send_drains(1);
    resize(3, 3);
    repeat (9) push_request(REQ_PIXEL, '1);
    drains_left = 3;
    send_drains(4);
    // single row frame, height zero taken as one
    resize(2, 0);
    push_request(REQ_PIXEL, 24'hFF00FF);
    push_request(REQ_PIXEL, 24'h00FF00);
    drains_left = 2;
    send_drains(1);
    // half drained row dropped by the next frame, width zero taken as one
    settle();
    set_frame_size(0, 2);
    push_request(REQ_PIXEL, 24'hA5C35A);
    push_request(REQ_PIXEL, 24'h5A3CA5);
    drains_left = 1;
    send_drains(1);
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    for (int part = 0; part < 3; part++) begin
      case (part)
        0: begin
          send_gap_pct = 10;
          sink_stall_pct = 58;
          directed_requests();
        end
        1: begin
          send_gap_pct = 58;
          sink_stall_pct = 10;
        end
        default: begin
          send_gap_pct = 0;
          sink_stall_pct = 0;
        end
      endcase
      random_flow(RANDOM_ITEMS / 3);
      case (part)
        0: touch_size_limits(2048, 0);
        1: touch_size_limits(0, 4095);
        default: touch_size_limits(4095, 1);
      endcase
    end
    send_drains(drains_left);
    settle();
    $display("run covered %0d pixel and %0d drain requests, %0d smoothed pixels checked",
             sb.pixels_seen, sb.drains_seen, sb.results_checked);
    $display("%0d frame size writes: zero, full and over-range sizes, mid-frame shrinks",
             sb.size_writes);
    if (sb.errors == 0 && sb.pending_results.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule
